### hdl/assert_macros.svh
// assertion macros shared by the softmax/argmax rtl
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define SFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define SFA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/sfa_pkg.sv
// shared types, widths and tables of the softmax/argmax block
// no dependencies; imported by sfa_div and softmax_argmax
`default_nettype none

package sfa_pkg;

   // fixed field widths
   localparam int LOGIT_W = 16;
   localparam int CFG_W   = 11;
   localparam int PROB_W  = 16;
   localparam int INDEX_W = 10;
   localparam int EXP_W   = 16;
   localparam int STORE_W = 17;
   localparam int Q_W     = 17;

   localparam int MAX_CLASSES_DEFAULT = 1024;

   localparam logic [CFG_W-1:0] CLASS_COUNT_RESET = 11'd1000;

   // log2(e) in Q1.15
   localparam logic [15:0] LOG2E_Q15 = 16'd47274;

   // round(65536 * 2^(-j/16)), j = 0..16
   localparam logic [16:0] POW2_NEG_TAB [0:16] = '{
      17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
      17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
      17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
   };

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_EXP,
      ST_DREAD,
      ST_DSTART,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

### hdl/sfa_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module sfa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/sfa_div.sv
// restoring divider, one quotient bit per cycle, Q_W quotient bits
// depends on sfa_pkg
`default_nettype none

module sfa_div import sfa_pkg::*; #(
   parameter int NUM_W = 33,
   parameter int DEN_W = 26
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [NUM_W-1:0]   numer,
   input  wire logic [DEN_W-1:0]   denom,
   output logic      [Q_W-1:0]     quot,
   output div_stat_type            stat
);

   localparam int REM_W  = DEN_W + 1;
   localparam int STEP_W = $clog2(Q_W);

   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [Q_W-1:0]    low_ff,  low_in;
   logic [DEN_W-1:0]  den_ff,  den_in;
   logic [Q_W-1:0]    q_ff,    q_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [REM_W-1:0]  cand;
   logic              ge;

   // one shift-subtract step per cycle
   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cand    = {rem_ff[REM_W-2:0], low_ff[Q_W-1]};
      ge      = (cand >= {1'b0, den_ff});
      if (start) begin
         // upper numerator bits are known to be below the divisor
         rem_in  = REM_W'(numer[NUM_W-1:Q_W]);
         low_in  = numer[Q_W-1:0];
         den_in  = denom;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? (cand - {1'b0, den_ff}) : cand;
         q_in    = {q_ff[Q_W-2:0], ge};
         low_in  = {low_ff[Q_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(Q_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign quot      = q_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

### hdl/softmax_argmax.sv
// softmax over one vector of classifier scores followed by argmax
// depends on sfa_pkg, sfa_ram, sfa_div and assert_macros.svh
//
// Scores (signed Q8.8) are taken one per cycle into a score ram while the
// running maximum is kept. After class_count scores (0 acts as 1, values
// above MAX_CLASSES act as MAX_CLASSES) the block stops taking items and
// runs two passes over the ram. The exponent pass is a four-stage pipeline
// that reads one entry per cycle, writes back exp(score - max) in Q0.16 and
// builds the sum. The divide pass then reads each value, divides it by the
// sum in a shared divider that retires one quotient bit per cycle, and keeps
// the first largest probability. No new score is taken until the divide
// pass is over, nor while the previous result still waits in the output
// register. The result goes to an output register; loading of the next
// vector starts while it waits to be taken. The ram is never cleared:
// every entry is written before it is read.
`default_nettype none

module softmax_argmax import sfa_pkg::*; #(
   parameter int MAX_CLASSES = MAX_CLASSES_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // score items
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic signed [LOGIT_W-1:0] req_logit,
   // result items
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [PROB_W-1:0]              rsp_best_prob,
   output logic [INDEX_W-1:0]             rsp_best_index,
   // class_count register
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CFG_W-1:0]          csr_class_count
);

`include "assert_macros.svh"

   localparam int ADDR_W = $clog2(MAX_CLASSES);
   localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
   localparam int SUM_W  = EXP_W + $clog2(MAX_CLASSES);
   localparam int NUM_W  = ((SUM_W - 1 > 2 * EXP_W) ? SUM_W - 1 : 2 * EXP_W) + 1;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]          class_count_ff, class_count_in;
   logic [CNT_W-1:0]          load_count_ff,  load_count_in;
   logic signed [LOGIT_W-1:0] max_ff,         max_in;
   logic [SUM_W-1:0]          sum_ff,         sum_in;
   logic [CNT_W-1:0]          rd_idx_ff,      rd_idx_in;

   // exponent pipeline
   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_idx_ff;
   logic              s2_valid_ff;
   logic [ADDR_W-1:0] s2_idx_ff;
   logic [31:0]       t_ff;
   logic              s3_valid_ff;
   logic [ADDR_W-1:0] s3_idx_ff;
   logic [16:0]       ta_ff;
   logic [8:0]        k_ff;
   logic [23:0]       prod_ff;

   // divide pass
   logic [ADDR_W-1:0]  j_ff,         j_in;
   logic [PROB_W-1:0]  best_prob_ff, best_prob_in;
   logic [INDEX_W-1:0] best_cls_ff,  best_cls_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PROB_W-1:0]  rsp_prob_ff,  rsp_prob_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;

   logic [CNT_W-1:0]   n_eff;
   logic [CNT_W-1:0]   n_last;
   logic               req_fire;
   logic               csr_fire;
   logic               last_item;
   logic               exp_rd;
   logic               exp_last_wr;
   logic               div_last;
   logic               rsp_load;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [STORE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [STORE_W-1:0] ram_rd_data;

   logic [16:0]        diff17;
   logic [31:0]        t_in;
   logic [3:0]         tab_i;
   logic [11:0]        tab_r;
   logic [16:0]        ta_in;
   logic [16:0]        tb;
   logic [16:0]        ta_tb;
   logic [23:0]        prod_in;
   logic [24:0]        rnd;
   logic [16:0]        m_val;
   logic [16:0]        e_shift;
   logic [EXP_W-1:0]   e_val;

   logic               div_start;
   logic [NUM_W-1:0]   div_numer;
   logic [Q_W-1:0]     div_quot;
   div_stat_type       div_stat;
   logic [PROB_W-1:0]  prob_sat;

   // effective class count
   always_comb begin
      if (class_count_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (32'(class_count_ff) > MAX_CLASSES) begin
         n_eff = CNT_W'(MAX_CLASSES);
      end else begin
         n_eff = CNT_W'(class_count_ff);
      end
   end

   assign n_last      = n_eff - CNT_W'(1);
   assign req_ready   = (state_ff == ST_LOAD);
   assign csr_ready   = (state_ff == ST_LOAD);
   assign req_fire    = req_valid && req_ready;
   assign csr_fire    = csr_valid && csr_ready;
   assign last_item   = (load_count_ff == n_last);
   assign exp_rd      = (state_ff == ST_EXP) && (rd_idx_ff < n_eff);
   assign exp_last_wr = s3_valid_ff && (CNT_W'(s3_idx_ff) == n_last);
   assign div_last    = (CNT_W'(j_ff) == n_last);
   assign prob_sat    = div_quot[Q_W-1] ? {PROB_W{1'b1}} : div_quot[PROB_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && last_item) begin
               state_in = ST_EXP;
            end
         end
         ST_EXP: begin
            if (exp_last_wr) begin
               state_in = ST_DREAD;
            end
         end
         ST_DREAD:  state_in = ST_DSTART;
         ST_DSTART: state_in = ST_DIV;
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = div_last ? ST_DONE : ST_DREAD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // exponent pipeline datapath
   always_comb begin
      diff17  = {max_ff[LOGIT_W-1], max_ff} - ram_rd_data;
      t_in    = {16'b0, diff17[15:0]} * {16'b0, LOG2E_Q15};
      tab_i   = t_ff[22:19];
      tab_r   = t_ff[18:7];
      ta_in   = POW2_NEG_TAB[{1'b0, tab_i}];
      tb      = POW2_NEG_TAB[{1'b0, tab_i} + 5'd1];
      ta_tb   = ta_in - tb;
      prod_in = {12'b0, ta_tb[11:0]} * {12'b0, tab_r};
      rnd     = ({1'b0, prod_ff} + 25'd2048) >> 12;
      m_val   = ta_ff - rnd[16:0];
      e_shift = (k_ff >= 9'd17) ? 17'd0 : (m_val >> k_ff[4:0]);
      e_val   = e_shift[16] ? {EXP_W{1'b1}} : e_shift[EXP_W-1:0];
   end

   // control outputs and register updates
   always_comb begin
      class_count_in = class_count_ff;
      load_count_in  = load_count_ff;
      max_in         = max_ff;
      sum_in         = sum_ff;
      rd_idx_in      = rd_idx_ff;
      j_in           = j_ff;
      best_prob_in   = best_prob_ff;
      best_cls_in    = best_cls_ff;
      rsp_load       = 1'b0;
      div_start      = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = s3_idx_ff;
      ram_wr_data    = {1'b0, e_val};
      ram_rd_en      = 1'b0;
      ram_rd_addr    = rd_idx_ff[ADDR_W-1:0];
      div_numer      = NUM_W'({ram_rd_data[EXP_W-1:0], {EXP_W{1'b0}}})
                       + NUM_W'(sum_ff >> 1);
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = load_count_ff[ADDR_W-1:0];
               ram_wr_data = {req_logit[LOGIT_W-1], req_logit};
               if (load_count_ff == '0 || req_logit > max_ff) begin
                  max_in = req_logit;
               end
               if (last_item) begin
                  load_count_in = '0;
                  sum_in        = '0;
                  rd_idx_in     = '0;
               end else begin
                  load_count_in = load_count_ff + CNT_W'(1);
               end
            end
            // a register write restarts loading
            if (csr_fire) begin
               class_count_in = csr_class_count;
               load_count_in  = '0;
               max_in         = '0;
            end
         end
         ST_EXP: begin
            ram_rd_en = exp_rd;
            if (exp_rd) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            if (s3_valid_ff) begin
               ram_wr_en = 1'b1;
               sum_in    = sum_ff + SUM_W'(e_val);
            end
            if (exp_last_wr) begin
               j_in         = '0;
               best_prob_in = '0;
               best_cls_in  = '0;
               max_in       = '0;
            end
         end
         ST_DREAD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = j_ff;
         end
         ST_DSTART: begin
            div_start = 1'b1;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               // strictly greater keeps the first index on ties
               if (prob_sat > best_prob_ff) begin
                  best_prob_in = prob_sat;
                  best_cls_in  = INDEX_W'(j_ff);
               end
               if (!div_last) begin
                  j_in = j_ff + ADDR_W'(1);
               end
            end
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_prob_in  = rsp_prob_ff;
      rsp_index_in = rsp_index_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_prob_in  = best_prob_ff;
         rsp_index_in = best_cls_ff;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         class_count_ff <= CLASS_COUNT_RESET;
         load_count_ff  <= '0;
         max_ff         <= '0;
         sum_ff         <= '0;
         rd_idx_ff      <= '0;
         j_ff           <= '0;
         best_prob_ff   <= '0;
         best_cls_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         class_count_ff <= class_count_in;
         load_count_ff  <= load_count_in;
         max_ff         <= max_in;
         sum_ff         <= sum_in;
         rd_idx_ff      <= rd_idx_in;
         j_ff           <= j_in;
         best_prob_ff   <= best_prob_in;
         best_cls_ff    <= best_cls_in;
         rsp_valid_ff   <= rsp_valid_in;
         s1_valid_ff    <= exp_rd;
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
      end
      s1_idx_ff    <= rd_idx_ff[ADDR_W-1:0];
      s2_idx_ff    <= s1_idx_ff;
      t_ff         <= t_in;
      s3_idx_ff    <= s2_idx_ff;
      ta_ff        <= ta_in;
      k_ff         <= t_ff[31:23];
      prod_ff      <= prod_in;
      rsp_prob_ff  <= rsp_prob_in;
      rsp_index_ff <= rsp_index_in;
   end

   // score and exponent store
   sfa_ram #(
      .WIDTH (STORE_W),
      .DEPTH (MAX_CLASSES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // probability divider
   sfa_div #(
      .NUM_W (NUM_W),
      .DEN_W (SUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (sum_ff),
      .quot  (div_quot),
      .stat  (div_stat)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_best_prob  = rsp_prob_ff;
   assign rsp_best_index = rsp_index_ff;

   // checks
   `SFA_ASSERT(a_load_pipe_empty, clock, reset, (state_ff == ST_LOAD) |-> !(s1_valid_ff || s2_valid_ff || s3_valid_ff), "exp pipeline active while loading")
   `SFA_ASSERT(a_div_start_idle, clock, reset, div_start |-> !div_stat.busy, "divider restarted while busy")
   `SFA_ASSERT(a_exp_wr_range, clock, reset, s3_valid_ff |-> (CNT_W'(s3_idx_ff) < n_eff), "exp write beyond vector")
   `SFA_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE), "result item raised outside done")
   `SFA_ASSERT_ALWAYS(a_reset_rsp, clock, reset |=> !rsp_valid_ff, "result item valid after reset")

endmodule

`default_nettype wire

### tb/sv/softmax_argmax_tb.sv
// self-checking testbench for softmax_argmax: score items in, top class items out
// depends on sfa_pkg and the softmax_argmax rtl; predicts each vector's top class itself
`timescale 1ns / 100ps

module softmax_argmax_tb import sfa_pkg::*; ();

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 64;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_SCORES = 250;
   localparam int MAX_CLS       = MAX_CLASSES_DEFAULT;
   localparam longint unsigned LOG2E_Q1_15 = 47274;

   // 2^(-j/16) in Q1.16, j = 0..16
   localparam int unsigned EXP2_FRAC_TAB [0:16] = '{
      65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
      46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768
   };

   typedef struct packed {
      logic [PROB_W-1:0]  prob;
      logic [INDEX_W-1:0] index;
   } top_class_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [LOGIT_W-1:0] req_logit = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [PROB_W-1:0]         rsp_best_prob;
   logic [INDEX_W-1:0]        rsp_best_index;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CFG_W-1:0]          csr_class_count = '0;

   // predictor state
   logic [CFG_W-1:0] cfg_count = CLASS_COUNT_RESET;
   int               score_mem [MAX_CLS];
   int               run_max = 0;
   int               load_cnt = 0;

   top_class_type pending_top_q [$];
   int            fault_count = 0;
   int            results_checked = 0;
   int            score_count = 0;
   int            cycle_count = 0;
   logic          no_gaps = 1'b0;
   logic          rsp_hold = 1'b0;
   int            rsp_wait = 0;
   int            rsp_draw;
   event          hold_ev;

   softmax_argmax #(
      .MAX_CLASSES (MAX_CLS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_logit       (req_logit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_best_prob   (rsp_best_prob),
      .rsp_best_index  (rsp_best_index),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_class_count (csr_class_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_top_q.size());
      $display("Regression FAIL");
      $finish;
   end

   // exp(-d) for a Q8.8 distance d, Q0.16 result saturated to 65535
   function automatic int unsigned exp_neg_q16(input int unsigned d);
      longint unsigned t;
      int unsigned     k, f, i, r, m, e;
      t = d;
      t = t * LOG2E_Q1_15;
      k = int'(t >> 23);
      f = int'((t >> 7) & 64'hFFFF);
      i = f >> 12;
      r = f & 32'hFFF;
      m = EXP2_FRAC_TAB[i] -
          (((EXP2_FRAC_TAB[i] - EXP2_FRAC_TAB[i+1]) * r + 2048) >> 12);
      e = (k >= 17) ? 0 : (m >> k);
      return (e > 65535) ? 65535 : e;
   endfunction

   // take one score; on the last score of a vector produce its top class
   function automatic bit absorb_score(input logic signed [LOGIT_W-1:0] s,
                                       output top_class_type top);
      int              n, j, sv;
      int unsigned     e, sum;
      longint unsigned p;
      n = (cfg_count == 0) ? 1 : ((cfg_count > MAX_CLS) ? MAX_CLS : int'(cfg_count));
      sv = s;
      top = '0;
      score_mem[load_cnt % MAX_CLS] = sv;
      if (load_cnt == 0 || sv > run_max) run_max = sv;
      load_cnt++;
      if (load_cnt < n) return 1'b0;
      // exponent pass with sum
      sum = 0;
      for (j = 0; j < n; j++) begin
         e = exp_neg_q16(run_max - score_mem[j]);
         score_mem[j] = e;
         sum += e;
      end
      // rounded divide, saturating
      for (j = 0; j < n; j++) begin
         p = ((longint'(score_mem[j]) << 16) + (sum >> 1)) / sum;
         score_mem[j] = (p > 65535) ? 65535 : int'(p);
      end
      // first largest wins
      for (j = 0; j < n; j++) begin
         if (score_mem[j] > top.prob) begin
            top.prob  = PROB_W'(score_mem[j]);
            top.index = j[INDEX_W-1:0];
         end
      end
      load_cnt = 0;
      run_max = 0;
      return 1'b1;
   endfunction

   // random score: full range, narrow spread, near ties or extremes
   function automatic logic signed [LOGIT_W-1:0] draw_score(input int mode, input int base);
      int v;
      case (mode)
         0: v = int'($urandom_range(0, 65535)) - 32768;
         1: v = base + int'($urandom_range(0, 2047)) - 1024;
         2: v = base + 64 * int'($urandom_range(0, 2));
         default: begin
            case ($urandom_range(0, 2))
               0: v = -32768;
               1: v = 32767;
               default: v = int'($urandom_range(0, 65535)) - 32768;
            endcase
         end
      endcase
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return LOGIT_W'(v);
   endfunction

   // send one score item, predict on acceptance
   task automatic send_score(input logic signed [LOGIT_W-1:0] value);
      int            gap;
      top_class_type top;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_logit <= value;
      do @(posedge clock); while (!req_ready);
      score_count++;
      if (absorb_score(value, top)) pending_top_q.push_back(top);
   endtask

   // drop valid and wait for every expected result, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_top_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // class_count write; loading restarts
   task automatic write_class_count(input logic [CFG_W-1:0] value);
      csr_valid       <= 1'b1;
      csr_class_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cfg_count = value;
      load_cnt  = 0;
      run_max   = 0;
   endtask

   // compare one accepted result against the oldest expectation
   task automatic check_top_class();
      top_class_type want;
      results_checked++;
      if (pending_top_q.size() == 0) begin
         fault_count++;
         if (fault_count <= 10)
            $display("unexpected result: best_prob %0d best_index %0d",
                     rsp_best_prob, rsp_best_index);
         return;
      end
      want = pending_top_q.pop_front();
      if (rsp_best_prob !== want.prob || rsp_best_index !== want.index) begin
         fault_count++;
         if (fault_count <= 10)
            $display("mismatch on result %0d: best_prob exp %0d got %0d, best_index exp %0d got %0d",
                     results_checked, want.prob, rsp_best_prob, want.index, rsp_best_index);
      end
   endtask

   // result side: check, then random stalls per item
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_top_class();
         if (rsp_hold) begin
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            rsp_draw = no_gaps ? 0 : $urandom_range(0, 7);
            rsp_wait  <= rsp_draw;
            rsp_ready <= (rsp_draw == 0);
         end else if (rsp_wait != 0) begin
            rsp_wait  <= rsp_wait - 1;
            rsp_ready <= (rsp_wait == 1);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // long output hold-off
   initial begin
      forever begin
         @(hold_ev);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // one vector at the reset length, tie at the top between two classes
   task automatic test_reset_length();
      int i;
      for (i = 0; i < 1000; i++) begin
         if (i == 700 || i == 900) send_score(16'sd32767);
         else send_score(LOGIT_W'(32767 - int'($urandom_range(1, 1500))));
      end
   endtask

   // field extremes, ties, saturation and the zero count
   task automatic test_corner_scores();
      wait_idle();
      write_class_count(CFG_W'(4));
      send_score(-16'sd32768); send_score(16'sd32767); send_score(16'sd0); send_score(-16'sd1);
      repeat (4) send_score(16'sd100);
      repeat (4) send_score(-16'sd32768);
      send_score(-16'sd256); send_score(16'sd0); send_score(16'sd256); send_score(16'sd256);
      send_score(16'sd32767); send_score(-16'sd32768); send_score(16'sd32767); send_score(16'sd1);
      wait_idle();
      // zero count acts as one
      write_class_count(CFG_W'(0));
      send_score(16'sd32767);
      send_score(-16'sd32768);
      wait_idle();
      write_class_count(CFG_W'(1));
      send_score(16'sd5);
      send_score(-16'sd7);
   endtask

   // count above the store size acts as the store size; top at the last index
   task automatic test_count_limit();
      int i;
      wait_idle();
      write_class_count('1);
      for (i = 0; i < MAX_CLS; i++) begin
         if (i == MAX_CLS - 1) send_score(-16'sd18000);
         else send_score(LOGIT_W'(-20000 + int'($urandom_range(0, 1999))));
      end
   endtask

   // write during a partial vector drops the loaded scores and their maximum
   task automatic test_restart();
      int i;
      wait_idle();
      write_class_count(CFG_W'(6));
      repeat (3) send_score(16'sd32767);
      wait_idle();
      write_class_count(CFG_W'(5));
      for (i = 0; i < 5; i++) send_score(LOGIT_W'(-1000 - 100 * i));
   endtask

   // receiver holds off while scores keep coming, so the input backs up
   task automatic test_output_stall();
      wait_idle();
      write_class_count(CFG_W'(2));
      no_gaps <= 1'b1;
      -> hold_ev;
      repeat (16) send_score(draw_score(1, 0));
      no_gaps <= 1'b0;
   endtask

   // random counts and vectors, with some broken vectors cut by a write
   task automatic test_random_vectors();
      int          stop_at, n, vecs, mode, base, cut, i;
      logic [CFG_W-1:0] count;
      stop_at = score_count + RANDOM_SCORES;
      while (score_count < stop_at) begin
         wait_idle();
         case ($urandom_range(0, 19))
            0:          count = '0;
            1:          count = CFG_W'($urandom_range(33, 96));
            2, 3, 4, 5: count = CFG_W'($urandom_range(9, 32));
            default:    count = CFG_W'($urandom_range(1, 8));
         endcase
         write_class_count(count);
         no_gaps <= ($urandom_range(0, 3) == 0);
         n = (count == 0) ? 1 : int'(count);
         vecs = $urandom_range(1, 5);
         repeat (vecs) begin
            mode = $urandom_range(0, 3);
            base = int'($urandom_range(0, 65535)) - 32768;
            for (i = 0; i < n; i++) send_score(draw_score(mode, base));
         end
         if (n > 1 && $urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, n - 1);
            repeat (cut) send_score(draw_score(0, 0));
         end
      end
      no_gaps <= 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_length();
      test_corner_scores();
      test_count_limit();
      test_restart();
      test_output_stall();
      test_random_vectors();
      wait_idle();
      $display("checked %0d top-class results from %0d scores, class counts 0 to 2047,",
               results_checked, score_count);
      $display("with load restarts, tied and saturated scores and a %0d-cycle output hold",
               HOLD_CYCLES);
      if (fault_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
